FILE: sv/i2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers of the integer to ascii formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int Q_DEPTH        = 2;

  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_LHEX = 2'd2;
  localparam logic [1:0] KIND_UHEX = 2'd3;

  localparam logic [6:0] MINUS_CODE = 7'h2D;
  localparam logic [6:0] ZERO_CODE  = 7'h30;
  localparam logic [6:0] LOWER_A    = 7'h61;
  localparam logic [6:0] UPPER_A    = 7'h41;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic [7:0]  width;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        is_dec;
    logic        neg;
    logic        upper;
    logic [3:0]  top_nib;
    logic [63:0] mag;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SIGN,
    B_DEC,
    B_HEX
  } back_state_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [6:0] code;
    if (nib < 4'd10) begin
      code = ZERO_CODE + {3'b000, nib};
    end else begin
      code = (upper ? UPPER_A : LOWER_A) + {3'b000, nib - 4'd10};
    end
    return code;
  endfunction

endpackage

FILE: sv/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a value as signed/unsigned decimal or lower/upper case hex ascii.
//
//   channel  | ports                      | payload
//   input    | in_valid, in_stall         | in_data  (kind, value, width)
//   output   | out_valid, out_stall       | out_data (char_code, last)
//
// hex: after the job is taken from the queue, digits go out from the first one
// to print down to the lowest, each when the output register can take it
// decimal: VALUE_BITS steps of the back end's single shift-and-add-3 converter,
// then the minus sign if negative, then digits from the top one (DEC_DIGITS) down
// a two-entry job queue lets the input run ahead of a stalled output
// synchronous active-low reset clears the queue, the sequencer and out_valid
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2a_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2a_pkg::out_item_t out_data
);
  import i2a_pkg::*;

  job_t front_job;
  job_t q_data;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  i2a_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .item (in_data),
    .job  (front_job)
  );

  i2a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  i2a_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/i2a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_front
// Classifies a request: masks the value, takes the magnitude of a negative
// signed value and finds the first hex digit to print.
// ----------------------------------------------------------------------------
module i2a_front #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  i2a_pkg::in_item_t item,
  output i2a_pkg::job_t     job
);
  import i2a_pkg::*;

  localparam int NBYTES = (VALUE_BITS + 7) / 8;

  logic [63:0] mask;
  logic [63:0] v;
  logic [63:0] neg_v;
  logic        sign;
  logic [2:0]  top_byte_min;
  logic [2:0]  top_byte;
  logic [8:0]  cnt_w;
  logic        hi_zero;
  logic        neg;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      mask[i] = (i < VALUE_BITS);
    end
    v     = item.value & mask;
    neg_v = (~v + 64'd1) & mask;
    sign  = v[VALUE_BITS-1];

    // highest nonzero byte, lowest byte if all zero
    top_byte_min = 3'd0;
    for (int b = 0; b < NBYTES; b++) begin
      if (v[8*b +: 8] != 8'd0) begin
        top_byte_min = 3'(b);
      end
    end

    cnt_w = ({1'b0, item.width} + 9'd1) >> 1;
    if (cnt_w > 9'(NBYTES)) begin
      cnt_w = 9'(NBYTES);
    end

    top_byte = (item.width == 8'd0) ? top_byte_min : 3'(cnt_w - 9'd1);
    hi_zero  = (v[{top_byte, 3'd4} +: 4] == 4'd0);
    neg      = (item.kind == KIND_SDEC) && sign;

    job.is_dec  = (item.kind == KIND_SDEC) || (item.kind == KIND_UDEC);
    job.neg     = neg;
    job.upper   = (item.kind == KIND_UHEX);
    job.top_nib = ((item.width == 8'd0) && hi_zero) ? {top_byte, 1'b0} : {top_byte, 1'b1};
    job.mag     = neg ? neg_v : v;
  end

endmodule

FILE: sv/i2a_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module i2a_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  i2a_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output i2a_pkg::job_t pop_data
);
  import i2a_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (cnt_r == CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

endmodule

FILE: sv/i2a_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_back
// Runs one job: shift-and-add-3 conversion for a decimal job, then emits
// characters through the output register.
// ----------------------------------------------------------------------------
module i2a_back #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  i2a_pkg::job_t     q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output i2a_pkg::out_item_t out_data
);
  import i2a_pkg::*;

  localparam int NBYTES     = (VALUE_BITS + 7) / 8;
  localparam int HEX_BITS   = 8 * NBYTES;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS   = 4 * DEC_DIGITS;
  localparam int IDX_W      = $clog2(DEC_DIGITS);
  localparam int NIB_W      = $clog2(2 * NBYTES);
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  back_state_t         state_r, state_nxt;
  logic [HEX_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_BITS-1:0] bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0] bcd_adj;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NIB_W-1:0]    nib_r, nib_nxt;
  logic                started_r, started_nxt;
  logic                neg_r, neg_nxt;
  logic                upper_r, upper_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                can_load;
  logic                load;
  out_item_t           load_data;
  logic [3:0]          dec_digit;
  logic [3:0]          hex_nib;

  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                    : bcd_r[4*d +: 4];
    end
  end

  assign can_load  = !out_valid_r || !out_stall;
  assign dec_digit = bcd_r[{idx_r, 2'b00} +: 4];
  assign hex_nib   = bin_r[{nib_r, 2'b00} +: 4];

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    nib_nxt     = nib_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    upper_nxt   = upper_r;
    q_pop       = 1'b0;
    load        = 1'b0;
    load_data   = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bin_nxt   = q_data.mag[HEX_BITS-1:0];
          neg_nxt   = q_data.neg;
          upper_nxt = q_data.upper;
          nib_nxt   = q_data.top_nib[NIB_W-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = q_data.is_dec ? B_CONV : B_HEX;
        end
      end
      B_CONV: begin
        bcd_nxt = {bcd_adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          idx_nxt     = IDX_W'(DEC_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? B_SIGN : B_DEC;
        end
      end
      B_SIGN: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = '{char_code: MINUS_CODE, last: 1'b0};
          state_nxt = B_DEC;
        end
      end
      B_DEC: begin
        // skip leading zeros
        if (!started_r && dec_digit == 4'd0 && idx_r != '0) begin
          idx_nxt = idx_r - IDX_W'(1);
        end else if (can_load) begin
          load        = 1'b1;
          load_data   = '{char_code: ZERO_CODE + {3'b000, dec_digit},
                          last: (idx_r == '0)};
          started_nxt = 1'b1;
          if (idx_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      B_HEX: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = '{char_code: hex_char(hex_nib, upper_r), last: (nib_r == '0)};
          if (nib_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            nib_nxt = nib_r - NIB_W'(1);
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    nib_r      <= nib_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CONV && state_nxt != B_CONV) |-> (cnt_r == CNT_LAST))
    else $error("conversion left early");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_data.last) |=> (state_r == B_IDLE))
    else $error("last character did not end the job");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> !load)
    else $error("character loaded while idle");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && state_r == B_IDLE))
    else $error("pop outside idle or from empty queue");
`endif

endmodule
